// ===== design/fta_pkg.sv =====
`default_nettype none
package fta_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int OWNER_BITS = 16;

	localparam int IDX_W      = $clog2(NUM_FRAMES);
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
	localparam int CFG_W      = 7;
	localparam int POS_W      = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int OWNER_IN_W = 16;
	localparam int OUT_IDX_W  = 6;
	localparam int OUT_CNT_W  = 7;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_PROC = 2'd2;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST  = 7'd64;
	localparam logic [CFG_W-1:0] FRAMES_PER_PROC_RST = 7'd4;

	localparam logic KIND_RESERVE = 1'b0;
	localparam logic KIND_TAKE    = 1'b1;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic mark;
		logic load_out;
	} fta_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic mark_done;
		logic found;
		logic take;
	} fta_sts_t;

endpackage
`default_nettype wire

// ===== design/fta_ram.sv =====
`default_nettype none
module fta_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/fta_ctrl.sv =====
`default_nettype none
module fta_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output fta_pkg::fta_cmd_t     cmd,
	input  wire fta_pkg::fta_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MARK,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd          = '0;
		cmd.start    = (state_q == ST_IDLE) && in_valid;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.commit   = (state_q == ST_DECIDE);
		cmd.mark     = (state_q == ST_MARK);
		cmd.load_out = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sts.found && !sts.take) begin
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MARK: begin
					if (sts.mark_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/fta_dp.sv =====
`default_nettype none
module fta_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fta_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                             in_kind,
	input  wire logic [fta_pkg::OWNER_IN_W-1:0]   in_owner,
	input  wire fta_pkg::fta_cmd_t                cmd,
	output fta_pkg::fta_sts_t                     sts,
	output logic                                  found,
	output logic [fta_pkg::OUT_IDX_W-1:0]         frame_index,
	output logic [fta_pkg::OUT_CNT_W-1:0]         free_count
);

	localparam int LW = fta_pkg::POS_W - 1;

	// configuration
	logic                        fixed_q;
	logic [fta_pkg::CFG_W-1:0]   fiu_q;
	logic [fta_pkg::CFG_W-1:0]   fpp_q;

	// frame table bits
	logic [fta_pkg::NUM_FRAMES-1:0] free_q;
	logic [fta_pkg::NUM_FRAMES-1:0] res_q;

	// item
	logic                          kind_q;
	logic [fta_pkg::OWNER_BITS-1:0] owner_q;

	// scan
	logic [fta_pkg::CNT_W-1:0] scan_idx_q;
	logic                      vld_s1;
	logic [fta_pkg::IDX_W-1:0] idx_s1;
	logic                      free_s1;
	logic                      res_s1;
	logic [fta_pkg::CNT_W-1:0] count_q;
	logic                      found_q;
	logic [fta_pkg::IDX_W-1:0] hit_q;
	logic [fta_pkg::CFG_W-1:0] k_q;

	// result
	logic                         res_found_q;
	logic [fta_pkg::OUT_IDX_W-1:0] res_idx_q;
	logic [fta_pkg::OUT_CNT_W-1:0] res_cnt_q;

	logic [LW-1:0]                  fiu_ext;
	logic [fta_pkg::CNT_W-1:0]      lim;
	logic                           scan_issue;
	logic [fta_pkg::IDX_W-1:0]      raddr;
	logic [fta_pkg::OWNER_BITS-1:0] rdata;
	logic [fta_pkg::OWNER_BITS-1:0] stored_owner;
	logic                           match;
	logic [fta_pkg::POS_W-1:0]      pos;
	logic                           mark_ok;
	logic                           mark_wr;
	logic                           take_hit;
	logic [fta_pkg::CNT_W-1:0]      final_cnt;

	assign fiu_ext = LW'(fiu_q);
	assign lim     = (fiu_ext > LW'(fta_pkg::NUM_FRAMES)) ?
		fta_pkg::CNT_W'(fta_pkg::NUM_FRAMES) : fta_pkg::CNT_W'(fiu_ext);

	assign scan_issue = cmd.scan && (scan_idx_q != lim);
	assign raddr      = scan_idx_q[fta_pkg::IDX_W-1:0];

	// unreserved frames were never written and read as owner zero
	assign stored_owner = res_s1 ? rdata : '0;
	assign match = (kind_q == fta_pkg::KIND_TAKE) ?
		(free_s1 && (!fixed_q || (stored_owner == owner_q))) : !res_s1;

	assign pos     = fta_pkg::POS_W'(hit_q) + fta_pkg::POS_W'(k_q);
	assign mark_ok = (fta_pkg::POS_W'(k_q) < fta_pkg::POS_W'(fpp_q)) &&
		(pos < fta_pkg::POS_W'(lim));
	assign mark_wr = cmd.mark && mark_ok;

	assign take_hit  = (kind_q == fta_pkg::KIND_TAKE) && found_q;
	assign final_cnt = count_q - fta_pkg::CNT_W'(take_hit);

	assign sts.scan_done = (scan_idx_q == lim);
	assign sts.mark_done = !mark_ok;
	assign sts.found     = found_q;
	assign sts.take      = (kind_q == fta_pkg::KIND_TAKE);

	assign found       = res_found_q;
	assign frame_index = res_idx_q;
	assign free_count  = res_cnt_q;

	fta_ram #(
		.WIDTH(fta_pkg::OWNER_BITS),
		.DEPTH(fta_pkg::NUM_FRAMES)
	) u_owner_ram (
		.clk   (clk),
		.we    (mark_wr),
		.waddr (pos[fta_pkg::IDX_W-1:0]),
		.wdata (owner_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b0;
			fiu_q   <= fta_pkg::FRAMES_IN_USE_RST;
			fpp_q   <= fta_pkg::FRAMES_PER_PROC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fta_pkg::REG_FIXED_MODE:      fixed_q <= cfg_data[0];
				fta_pkg::REG_FRAMES_IN_USE:   fiu_q   <= cfg_data;
				fta_pkg::REG_FRAMES_PER_PROC: fpp_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q     <= '1;
			res_q      <= '0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			count_q    <= '0;
			found_q    <= 1'b0;
			hit_q      <= '0;
			k_q        <= '0;
		end else begin
			if (cmd.start) begin
				scan_idx_q <= '0;
				vld_s1     <= 1'b0;
				count_q    <= '0;
				found_q    <= 1'b0;
				hit_q      <= '0;
				k_q        <= '0;
			end else begin
				vld_s1 <= scan_issue;
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (vld_s1) begin
					count_q <= count_q + fta_pkg::CNT_W'(free_s1);
					if (!found_q && match) begin
						found_q <= 1'b1;
						hit_q   <= idx_s1;
					end
				end
				if (cmd.commit && take_hit) begin
					free_q[hit_q] <= 1'b0;
				end
				if (mark_wr) begin
					res_q[pos[fta_pkg::IDX_W-1:0]] <= 1'b1;
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q  <= in_kind;
			owner_q <= fta_pkg::OWNER_BITS'(in_owner);
		end
		if (scan_issue) begin
			idx_s1  <= raddr;
			free_s1 <= free_q[raddr];
			res_s1  <= res_q[raddr];
		end
		if (cmd.load_out) begin
			res_found_q <= found_q;
			res_idx_q   <= fta_pkg::OUT_IDX_W'(hit_q);
			res_cnt_q   <= fta_pkg::OUT_CNT_W'(final_cnt);
		end
	end

endmodule
`default_nettype wire

// ===== design/frame_table_allocator_top.sv =====
// first-fit frame allocator over a table of frames (free bit, reserved bit, owner)
// input channel in_valid/in_ready carries one word: kind (reserve or take) and owner_id
// output channel out_valid/out_ready returns found, frame_index and free_count per word
// config channel cfg_valid/cfg_ready, cfg_index 0 fixed mode, 1 frames in use,
// 2 frames per process, other indexes ignored; always ready, write only while idle
// one word at a time: the scan reads one frame per cycle through the single owner ram
// read port; a take then passes a decide step and the output register load, and a new
// word is accepted once its result is loaded; a reserve that finds a frame adds a
// marking step that writes the clipped run through the write port
// free count is gathered over the whole scan, so every word walks all frames in use
// the result sits in an output register; a new word is taken while it waits, and the
// next result is held back until the receiver takes the previous one
// reset: all frames free, unreserved, owner zero; fixed mode 0, 64 frames in use,
// 4 frames per process; no clearing pass, the block is ready straight after reset
`default_nettype none
module frame_table_allocator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              kind,
	input  wire logic [fta_pkg::OWNER_IN_W-1:0]    owner_id,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   found,
	output logic [fta_pkg::OUT_IDX_W-1:0]          frame_index,
	output logic [fta_pkg::OUT_CNT_W-1:0]          free_count,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fta_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fta_pkg::CFG_W-1:0]         cfg_data
);

	fta_pkg::fta_cmd_t cmd;
	fta_pkg::fta_sts_t sts;

	assign cfg_ready = 1'b1;

	fta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fta_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_kind     (kind),
		.in_owner    (owner_id),
		.cmd         (cmd),
		.sts         (sts),
		.found       (found),
		.frame_index (frame_index),
		.free_count  (free_count)
	);

endmodule
`default_nettype wire

// ===== tb/frame_table_allocator_top_tb.sv =====
`timescale 1ns / 100ps
module frame_table_allocator_top_tb;
	import fta_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES      = 14;
	localparam int PHASE_WORDS = 64;
	localparam int SETTLE      = 4;
	localparam int TAIL        = 20;
	localparam int STALL_LIMIT = 3000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] idx;
		logic [OUT_CNT_W-1:0] cnt;
	} grant_t;

	class frame_book;
		bit                    frame_free [NUM_FRAMES];
		bit                    frame_held [NUM_FRAMES];
		logic [OWNER_BITS-1:0] holder [NUM_FRAMES];
		bit                    strict_owner;
		logic [CFG_W-1:0]      span;
		logic [CFG_W-1:0]      run_len;
		grant_t                pending_grants [$];
		int                    faults;

		function new();
			for (int i = 0; i < NUM_FRAMES; i++) begin
				frame_free[i] = 1'b1;
				frame_held[i] = 1'b0;
				holder[i] = '0;
			end
			strict_owner = 1'b0;
			span = FRAMES_IN_USE_RST;
			run_len = FRAMES_PER_PROC_RST;
			faults = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FIXED_MODE:      strict_owner = data[0];
				REG_FRAMES_IN_USE:   span = data;
				REG_FRAMES_PER_PROC: run_len = data;
				default: ;
			endcase
		endfunction

		// first-fit search, then mark the run or claim the frame
		function void note_request(logic k, logic [OWNER_IN_W-1:0] who);
			int lim;
			int i;
			int n;
			logic [OWNER_BITS-1:0] tag;
			grant_t g;
			lim = (span > NUM_FRAMES) ? NUM_FRAMES : int'(span);
			tag = who;
			g = '0;
			i = 0;
			if (k == KIND_RESERVE) begin
				while (i < lim && frame_held[i])
					i++;
				if (i < lim) begin
					g.found = 1'b1;
					g.idx = i[OUT_IDX_W-1:0];
					for (n = 0; n < run_len && i + n < lim; n++) begin
						frame_held[i + n] = 1'b1;
						holder[i + n] = tag;
					end
				end
			end else begin
				while (i < lim && !(frame_free[i] && (!strict_owner || holder[i] == tag)))
					i++;
				if (i < lim) begin
					frame_free[i] = 1'b0;
					g.found = 1'b1;
					g.idx = i[OUT_IDX_W-1:0];
				end
			end
			n = 0;
			for (i = 0; i < lim; i++)
				if (frame_free[i])
					n++;
			g.cnt = n[OUT_CNT_W-1:0];
			pending_grants.push_back(g);
		endfunction

		function void check_grant(grant_t got);
			grant_t want;
			if (pending_grants.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("unexpected result: found %0d index %0d free %0d",
						got.found, got.idx, got.cnt);
				return;
			end
			want = pending_grants.pop_front();
			if (got.found !== want.found || got.idx !== want.idx || got.cnt !== want.cnt) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("result mismatch: exp found %0d index %0d free %0d, got found %0d index %0d free %0d",
						want.found, want.idx, want.cnt, got.found, got.idx, got.cnt);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  kind;
	logic [OWNER_IN_W-1:0] owner_id;
	logic                  out_valid;
	logic                  out_ready;
	logic                  found;
	logic [OUT_IDX_W-1:0]  frame_index;
	logic [OUT_CNT_W-1:0]  free_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	frame_book             book = new();
	bit                    quiet = 1'b0;
	int                    stall_cycles = 0;
	logic [OWNER_IN_W-1:0] recent_owners [$];
	logic [CFG_W-1:0]      phase_span [PHASES] =
		'{10, 0, 16, 22, 1, 28, 34, 40, 46, 52, 58, 64, 127, 64};

	frame_table_allocator_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.owner_id    (owner_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.frame_index (frame_index),
		.free_count  (free_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				book.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				book.note_request(kind, owner_id);
			if (out_valid && out_ready)
				book.check_grant(grant_t'{found, frame_index, free_count});
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL frame_table_allocator_top");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : result_sink
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (quiet || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end
		end
	end

	task automatic send_word(input logic k, input logic [OWNER_IN_W-1:0] who);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		owner_id <= who;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// drain every outstanding word before touching the registers
	task automatic configure(input logic fm, input logic [CFG_W-1:0] fiu,
		input logic [CFG_W-1:0] fpp);
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		put_reg(REG_FIXED_MODE, {{(CFG_W-1){1'b0}}, fm});
		put_reg(REG_FRAMES_IN_USE, fiu);
		put_reg(REG_FRAMES_PER_PROC, fpp);
		put_reg(REG_UNUSED, CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [OWNER_IN_W-1:0] fresh_owner();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return OWNER_IN_W'($urandom);
	endfunction

	// often owners that hold a recent run, or owner zero, so fixed mode takes can succeed
	function automatic logic [OWNER_IN_W-1:0] known_owner();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && recent_owners.size() != 0)
			return recent_owners[$urandom_range(0, recent_owners.size() - 1)];
		if (roll < 6)
			return '0;
		if (roll == 6)
			return '1;
		return OWNER_IN_W'($urandom);
	endfunction

	initial begin : stimulus
		logic                  k;
		logic [OWNER_IN_W-1:0] pick;
		logic [CFG_W-1:0]      run;
		int                    roll;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_RESERVE;
		owner_id <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FIXED_MODE;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_word(KIND_RESERVE, 16'hFFFF);
		send_word(KIND_TAKE, 16'h0000);
		send_word(KIND_RESERVE, 16'h0000);
		// empty table
		configure(1'b1, 7'd0, 7'd4);
		send_word(KIND_RESERVE, 16'hFFFF);
		send_word(KIND_TAKE, 16'h0000);
		// oversized table, zero length run, owner matching
		configure(1'b1, 7'd127, 7'd0);
		send_word(KIND_RESERVE, 16'h1234);
		send_word(KIND_TAKE, 16'hFFFF);
		send_word(KIND_TAKE, 16'h5555);
		send_word(KIND_TAKE, 16'h0000);
		// run clipped at the table end
		configure(1'b0, 7'd10, 7'd64);
		send_word(KIND_RESERVE, 16'hABCD);
		send_word(KIND_RESERVE, 16'h0001);
		send_word(KIND_TAKE, 16'h7FFF);
		configure(1'b1, 7'd1, 7'd1);
		send_word(KIND_TAKE, 16'h0000);
		send_word(KIND_RESERVE, 16'h0000);
		configure(1'b0, 7'd12, 7'd127);
		send_word(KIND_RESERVE, 16'h8000);
		send_word(KIND_TAKE, 16'h8000);

		for (int p = 0; p < PHASES; p++) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				run = 7'd0;
			else if (roll == 1)
				run = 7'd64;
			else if (roll == 2)
				run = 7'd127;
			else
				run = CFG_W'($urandom_range(1, 3));
			configure(1'($urandom_range(0, 1)), phase_span[p], run);
			quiet = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				k = 1'($urandom_range(0, 1));
				if (k == KIND_RESERVE) begin
					pick = fresh_owner();
					recent_owners.push_back(pick);
					if (recent_owners.size() > 8)
						void'(recent_owners.pop_front());
				end else begin
					pick = known_owner();
				end
				send_word(k, pick);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending_grants.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (book.faults == 0 && book.pending_grants.size() == 0)
			$display("PASS frame_table_allocator_top");
		else
			$display("FAIL frame_table_allocator_top");
		$finish;
	end

endmodule
